[design/video_bitrate_congestion_controller_assert.svh]
// assertion macros shared by the congestion controller modules
`ifndef VIDEO_BITRATE_CONGESTION_CONTROLLER_ASSERT_SVH
`define VIDEO_BITRATE_CONGESTION_CONTROLLER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define VBCC_ASSERT_IMP(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("vbcc: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define VBCC_ASSERT_NXT(label, clk_i, rst_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("vbcc: next-cycle check failed");

`endif

[design/vbcc_pkg.sv]
package vbcc_pkg;

  // payload of one feedback sample
  typedef struct packed {
    logic [31:0] packets_received;
    logic [31:0] packets_lost;
    logic [31:0] round_trip_us;
    logic [31:0] decoder_age_us;
    logic [47:0] now_us;
  } sample_t;

  // payload of one result
  typedef struct packed {
    logic [19:0] target_rate_kbps;
    logic [1:0]  action_taken;
  } result_t;

  // action codes, also used as the verdict of the front
  typedef enum logic [1:0] {
    ACT_HOLD  = 2'd0,
    ACT_RAISE = 2'd1,
    ACT_CUT90 = 2'd2,
    ACT_CUT80 = 2'd3
  } action_t;

  // classified sample handed from front to back
  typedef struct packed {
    action_t     action;
    logic [47:0] now_us;
  } verdict_t;

  // queue depths
  localparam int VBCC_MID_DEPTH = 2;
  localparam int VBCC_OUT_DEPTH = 2;

  // rate register and derived values after reset; minimum ceiling, floor and raise steps; hold time in us
  localparam logic [19:0] CEIL_RESET    = 20'd20000;
  localparam logic [19:0] FLOOR_RESET   = 20'd7000;
  localparam logic [19:0] TARGET_RESET  = 20'd12000;
  localparam logic [19:0] STARTUP_RESET = 20'd17000;
  localparam logic [19:0] CEIL_MIN      = 20'd1000;
  localparam logic [19:0] FLOOR_MIN     = 20'd4000;
  localparam logic [19:0] STEP_LO_MIN   = 20'd500;
  localparam logic [19:0] STEP_HI_MIN   = 20'd250;
  localparam logic [47:0] HOLD_US       = 48'd300000;

  // loss per mille
  localparam int          LOSS_BITS   = 10;
  localparam logic [9:0]  LOSS_SCALE  = 10'd1000;
  localparam logic [9:0]  LOSS_SEVERE = 10'd20;
  localparam logic [9:0]  LOSS_PRESS  = 10'd5;
  localparam logic [9:0]  LOSS_CLEAN  = 10'd1;

  // queue delay and decode age thresholds in us
  localparam logic [31:0] QD_SEVERE  = 32'd15000;
  localparam logic [31:0] QD_PRESS   = 32'd8000;
  localparam logic [31:0] QD_CLEAN   = 32'd3000;
  localparam logic [31:0] AGE_SEVERE = 32'd80000;
  localparam logic [31:0] AGE_PRESS  = 32'd45000;
  localparam logic [31:0] AGE_CLEAN  = 32'd25000;

  // reciprocals: x/125 for x < 2^29, x/5 for x < 2^23
  localparam logic [29:0] RCP125       = 30'd549755814;
  localparam int          RCP125_SHIFT = 36;
  localparam logic [23:0] RCP5         = 24'd13421773;
  localparam int          RCP5_SHIFT   = 26;

endpackage

[design/vbcc_queue.sv]
module vbcc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  // handshake qualification
  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/vbcc_front.sv]
module vbcc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vbcc_pkg::sample_t  sample,
  output logic               full,
  output logic               verdict_push,
  output vbcc_pkg::verdict_t verdict,
  input  logic               verdict_full
);
  import vbcc_pkg::*;
  `include "video_bitrate_congestion_controller_assert.svh"

  localparam int CNT_W = $clog2(LOSS_BITS);

  typedef enum logic [2:0] {
    F_IDLE,
    F_PREP,
    F_BASE,
    F_DIV,
    F_PUSH
  } fstate_t;

  fstate_t              state;
  sample_t              smp;
  logic [31:0]          baseline;
  logic [28:0]          bl_x;
  logic [22:0]          bl_quot;
  logic [32:0]          total;
  logic                 zero_total;
  logic [32:0]          rem;
  logic [LOSS_BITS-1:0] dlow;
  logic [LOSS_BITS-1:0] quo;
  logic [CNT_W-1:0]     cnt;

  logic [41:0]          dividend;
  logic [58:0]          bl_prod;
  logic [33:0]          rem_shift;
  logic                 rem_ge;
  logic [LOSS_BITS-1:0] loss;
  logic [31:0]          qdelay;
  logic                 severe;
  logic                 pressured;
  logic                 clean;
  action_t              verdict_act;

  // loss dividend and baseline decay step (rtt - baseline)/1000 = ((d >> 3) / 125)
  assign dividend = 42'(smp.packets_lost) * 42'(LOSS_SCALE);
  assign bl_prod  = 59'(bl_x) * 59'(RCP125);

  // one restoring divide step per cycle
  assign rem_shift = {rem, dlow[LOSS_BITS-1]};
  assign rem_ge    = (rem_shift >= {1'b0, total});

  // classification from the updated baseline
  assign loss   = zero_total ? '0 : quo;
  assign qdelay = (smp.round_trip_us > baseline) ? smp.round_trip_us - baseline : '0;

  assign severe    = (loss >= LOSS_SEVERE) || (qdelay >= QD_SEVERE) ||
                     (smp.decoder_age_us >= AGE_SEVERE);
  assign pressured = (loss >= LOSS_PRESS) || (qdelay >= QD_PRESS) ||
                     (smp.decoder_age_us >= AGE_PRESS);
  assign clean     = (loss <= LOSS_CLEAN) && (qdelay <= QD_CLEAN) &&
                     (smp.decoder_age_us <= AGE_CLEAN);

  always_comb begin
    if (severe) begin
      verdict_act = ACT_CUT80;
    end else if (pressured) begin
      verdict_act = ACT_CUT90;
    end else if (clean) begin
      verdict_act = ACT_RAISE;
    end else begin
      verdict_act = ACT_HOLD;
    end
  end

  assign verdict.action = verdict_act;
  assign verdict.now_us = smp.now_us;
  assign verdict_push   = (state == F_PUSH) && !verdict_full;
  assign full           = (state != F_IDLE);

  // sequencer: capture, prepare, baseline update, divide, hand over
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= F_IDLE;
      baseline <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (push) begin
            smp   <= sample;
            bl_x  <= 29'((sample.round_trip_us - baseline) >> 3);
            state <= F_PREP;
          end
        end
        F_PREP: begin
          total      <= 33'(smp.packets_received) + 33'(smp.packets_lost);
          zero_total <= (smp.packets_received == '0) && (smp.packets_lost == '0);
          rem        <= 33'(dividend[41:LOSS_BITS]);
          dlow       <= dividend[LOSS_BITS-1:0];
          quo        <= '0;
          cnt        <= '0;
          bl_quot    <= 23'(bl_prod >> RCP125_SHIFT);
          state      <= F_BASE;
        end
        F_BASE: begin
          if (smp.round_trip_us != '0) begin
            if ((baseline == '0) || (smp.round_trip_us < baseline)) begin
              baseline <= smp.round_trip_us;
            end else begin
              baseline <= baseline + 32'(bl_quot);
            end
          end
          state <= F_DIV;
        end
        F_DIV: begin
          rem  <= rem_ge ? 33'(rem_shift - {1'b0, total}) : rem_shift[32:0];
          quo  <= {quo[LOSS_BITS-2:0], rem_ge};
          dlow <= {dlow[LOSS_BITS-2:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(LOSS_BITS - 1)) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!verdict_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `VBCC_ASSERT_NXT(a_baseline_set, clk, rst, (state == F_BASE) && (smp.round_trip_us != '0), baseline != '0)
  `VBCC_ASSERT_IMP(a_loss_range, clk, rst, (state == F_PUSH) && !zero_total, quo <= LOSS_SCALE)

endmodule

[design/vbcc_back.sv]
module vbcc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [19:0]        cfg_wdata,
  input  vbcc_pkg::verdict_t verdict,
  input  logic               verdict_empty,
  output logic               verdict_pop,
  output logic               result_push,
  output vbcc_pkg::result_t  result,
  input  logic               result_full
);
  import vbcc_pkg::*;
  `include "video_bitrate_congestion_controller_assert.svh"

  typedef enum logic [2:0] {
    B_IDLE,
    B_ITEM_MUL,
    B_ITEM_APPLY,
    B_CFG_LOAD,
    B_CFG_FLOOR,
    B_CFG_START,
    B_CFG_TARGET
  } bstate_t;

  // floor(v / 5) by reciprocal, v below 2^23
  function automatic logic [20:0] div5(input logic [22:0] v);
    logic [46:0] p;
    p = 47'(v) * 47'(RCP5);
    return 21'(p >> RCP5_SHIFT);
  endfunction

  bstate_t     state;
  logic [19:0] ceiling;
  logic [19:0] floor_rate;
  logic [19:0] target;
  logic [19:0] startup;
  logic        ever_adjusted;
  logic [47:0] last_adjust;
  action_t     act;
  logic [47:0] now_r;
  logic        raise_lo;
  logic [22:0] x;
  logic [20:0] q;

  logic [19:0] cv;
  logic [47:0] elapsed;
  action_t     act_next;
  logic [22:0] op_item;
  logic [19:0] q20;
  logic [19:0] step;
  logic [20:0] sum;
  logic [19:0] new_t;
  logic [19:0] floor_calc;
  logic [19:0] target_calc;

  // register write value, raised to the minimum ceiling
  assign cv = (cfg_wdata < CEIL_MIN) ? CEIL_MIN : cfg_wdata;

  // raise allowed once the hold time has passed, or before any adjustment
  assign elapsed = verdict.now_us - last_adjust;
  always_comb begin
    act_next = verdict.action;
    if ((verdict.action == ACT_RAISE) && ever_adjusted && (elapsed < HOLD_US)) begin
      act_next = ACT_HOLD;
    end
  end

  // divide-by-5 operand for the item: 80%, 90%, raise step /10 or /20
  always_comb begin
    case (act_next)
      ACT_CUT80: op_item = 23'({target, 2'b00});
      ACT_CUT90: op_item = 23'((24'(target) * 24'd9) >> 1);
      ACT_RAISE: op_item = (target < startup) ? 23'(target >> 1) : 23'(target >> 2);
      default:   op_item = 23'(target);
    endcase
  end

  // new target from the quotient
  assign q20 = q[19:0];
  always_comb begin
    if (raise_lo) begin
      step = (q20 < STEP_LO_MIN) ? STEP_LO_MIN : q20;
    end else begin
      step = (q20 < STEP_HI_MIN) ? STEP_HI_MIN : q20;
    end
    sum = 21'(target) + 21'(step);
    case (act)
      ACT_CUT80, ACT_CUT90: new_t = (q20 < floor_rate) ? floor_rate : q20;
      ACT_RAISE:            new_t = (sum > 21'(ceiling)) ? ceiling : sum[19:0];
      default:              new_t = target;
    endcase
  end

  // derived rates after a register write
  always_comb begin
    floor_calc = (q20 < FLOOR_MIN) ? FLOOR_MIN : q20;
    if (floor_calc > ceiling) begin
      floor_calc = ceiling;
    end
    target_calc = (q20 < floor_rate) ? floor_rate : q20;
    if (target_calc > ceiling) begin
      target_calc = ceiling;
    end
  end

  assign verdict_pop = (state == B_IDLE) && !verdict_empty && !result_full && !cfg_we;
  assign result_push = (state == B_ITEM_APPLY);
  assign result.target_rate_kbps = new_t;
  assign result.action_taken     = 2'(act);

  // sequencer around one shared divide-by-5 multiplier
  always_ff @(posedge clk) begin
    q <= div5(x);
    if (rst) begin
      state         <= B_IDLE;
      ceiling       <= CEIL_RESET;
      floor_rate    <= FLOOR_RESET;
      target        <= TARGET_RESET;
      startup       <= STARTUP_RESET;
      ever_adjusted <= 1'b0;
      last_adjust   <= '0;
    end else if (cfg_we) begin
      ceiling <= cv;
      x       <= 23'((23'(cv) * 23'd7) >> 2);
      state   <= B_CFG_LOAD;
    end else begin
      case (state)
        B_IDLE: begin
          if (verdict_pop) begin
            act      <= act_next;
            now_r    <= verdict.now_us;
            raise_lo <= (target < startup);
            x        <= op_item;
            state    <= B_ITEM_MUL;
          end
        end
        B_ITEM_MUL: begin
          state <= B_ITEM_APPLY;
        end
        B_ITEM_APPLY: begin
          target <= new_t;
          if (act != ACT_HOLD) begin
            last_adjust   <= now_r;
            ever_adjusted <= 1'b1;
          end
          state <= B_IDLE;
        end
        B_CFG_LOAD: begin
          x     <= 23'((25'(ceiling) * 25'd17) >> 2);
          state <= B_CFG_FLOOR;
        end
        B_CFG_FLOOR: begin
          floor_rate <= floor_calc;
          x          <= 23'(23'(ceiling) * 23'd3);
          state      <= B_CFG_START;
        end
        B_CFG_START: begin
          startup <= q20;
          state   <= B_CFG_TARGET;
        end
        B_CFG_TARGET: begin
          target <= target_calc;
          state  <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `VBCC_ASSERT_IMP(a_target_bounds, clk, rst, state == B_IDLE, (target >= floor_rate) && (target <= ceiling))
  `VBCC_ASSERT_IMP(a_result_room, clk, rst, result_push, !result_full)

endmodule

[design/video_bitrate_congestion_controller.sv]
// the front takes a new sample only after the last one is handed over, paced by the 10-step loss divider
// a register write keeps the back busy while floor, startup and target are rederived
// reset: synchronous; ceiling 20000, floor 7000, target 12000, baseline and timing cleared
// reset empties both queues; no clearing pass
module video_bitrate_congestion_controller #(
  parameter int MID_DEPTH = vbcc_pkg::VBCC_MID_DEPTH,
  parameter int OUT_DEPTH = vbcc_pkg::VBCC_OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  vbcc_pkg::sample_t sample,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output vbcc_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [19:0]       cfg_wdata
);
  import vbcc_pkg::*;

  verdict_t mid_in;
  logic     mid_push;
  logic     mid_full;
  logic [$bits(verdict_t)-1:0] mid_out;
  logic     mid_empty;
  logic     mid_pop;
  result_t  res_in;
  logic     res_push;
  logic     res_full;
  logic [$bits(result_t)-1:0] res_out;

  // classify samples
  vbcc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .sample       (sample),
    .full         (full),
    .verdict_push (mid_push),
    .verdict      (mid_in),
    .verdict_full (mid_full)
  );

  // verdicts between front and back
  vbcc_queue #(
    .WIDTH ($bits(verdict_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_out),
    .empty (mid_empty)
  );

  // rate update and register handling
  vbcc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .verdict       (verdict_t'(mid_out)),
    .verdict_empty (mid_empty),
    .verdict_pop   (mid_pop),
    .result_push   (res_push),
    .result        (res_in),
    .result_full   (res_full)
  );

  // result beats waiting to be taken
  vbcc_queue #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign result = result_t'(res_out);

endmodule
